[sv/wtd_pkg.sv]
package wtd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int AVG_W     = 24;
  localparam int TREND_W   = 2;
  localparam int HELD_W    = 6;
  localparam int FRAC_BITS = 8;

  localparam logic signed [TREND_W-1:0] TREND_UP   = 2'sb01;
  localparam logic signed [TREND_W-1:0] TREND_FLAT = 2'sb00;
  localparam logic signed [TREND_W-1:0] TREND_DOWN = 2'sb11;

  // main sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_CALC,
    S_LOAD
  } state_t;

  // multiplier schedule during S_CALC
  typedef enum logic [1:0] {
    M_RP,
    M_PK,
    M_KP,
    M_CMP
  } mul_step_t;

endpackage

[sv/windowed_average_trend_detector.sv]
// Windowed average and trend detector. Each input transaction carries one
// signed 16-bit sample, which is written into a ring of WINDOW entries; the
// fill count n saturates at WINDOW. Each input gives exactly one output
// transaction: the mean of the n stored samples in signed Q.8 (truncated
// toward zero), a trend flag (+1 / -1 / 0) comparing the mean of the newest
// n/2 samples against the mean of the older ones with an exact threshold of
// one half, and the fill count (low 6 bits). The block takes one sample at a
// time: after acceptance it walks the n newest ring entries through the
// single read port, then runs a restoring divider of 25 + log2(WINDOW) steps
// alongside the shared multiplier, loads the output register and returns to
// idle, ready for the next sample. The output register lets the next sample
// be accepted while a result is still waiting on out_ready; a second result
// waits in the load step until the first has gone. The ring needs no clear
// after reset: only entries already written are ever visited.
module windowed_average_trend_detector #(
  parameter int WINDOW = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [wtd_pkg::SAMPLE_W-1:0]  sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wtd_pkg::AVG_W-1:0]     average_q8,
  output logic signed [wtd_pkg::TREND_W-1:0]   trend,
  output logic        [wtd_pkg::HELD_W-1:0]    samples_held
);

  localparam int AW  = $clog2(WINDOW);          // ring address
  localparam int CW  = $clog2(WINDOW + 1);      // fill count, 0..WINDOW
  localparam int SW  = wtd_pkg::SAMPLE_W + 1 + AW; // signed window sum
  localparam int PW  = SW + CW + 1;             // multiplier product
  localparam int DFW = PW + 2;                  // doubled difference
  localparam int DW  = SW + wtd_pkg::FRAC_BITS; // dividend width

  wtd_pkg::state_t    state, state_next;
  wtd_pkg::mul_step_t mstep;

  // sample ring, single write / single registered read
  logic signed [wtd_pkg::SAMPLE_W-1:0] ring [WINDOW];
  logic signed [wtd_pkg::SAMPLE_W-1:0] rdata;

  logic [AW-1:0] wpos;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [AW-1:0] rptr;
  logic [CW-1:0] icnt;
  logic          rd_vld;
  logic          rd_tag;

  logic signed [SW-1:0] total, recent, prior;

  logic [CW-1:0] k_cnt, p_cnt;

  // shared multiplier
  logic signed [SW-1:0]  mul_a;
  logic signed [CW:0]    mul_b;
  logic signed [PW-1:0]  mul_q;
  logic signed [PW-1:0]  prod_rp;
  logic signed [DFW-1:0] diff2;
  logic signed [DFW-1:0] kp_ext;
  logic signed [wtd_pkg::TREND_W-1:0] trend_r;

  // divider
  logic          div_start;
  logic          div_busy;
  logic          total_neg;
  logic [SW-1:0] tot_mag;
  logic [DW-1:0] dividend;
  logic [DW-1:0] quotient;
  logic [DW-1:0] avg_full;

  logic accept;
  logic issue_en;
  logic walk_done;
  logic load_out;

  assign accept    = in_valid && in_ready;
  assign fill_next = (fill == CW'(WINDOW)) ? fill : fill + 1'b1;
  assign issue_en  = (state == wtd_pkg::S_WALK) && (icnt != fill);
  assign walk_done = (icnt == fill) && !rd_vld;
  assign k_cnt     = fill >> 1;
  assign p_cnt     = fill - k_cnt;

  // ---- sequencer: next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      wtd_pkg::S_IDLE: if (in_valid) state_next = wtd_pkg::S_WALK;
      wtd_pkg::S_WALK: if (walk_done) state_next = wtd_pkg::S_CALC;
      wtd_pkg::S_CALC: begin
        if (mstep == wtd_pkg::M_CMP && !div_busy) state_next = wtd_pkg::S_LOAD;
      end
      wtd_pkg::S_LOAD: if (!out_valid || out_ready) state_next = wtd_pkg::S_IDLE;
      default: state_next = wtd_pkg::S_IDLE;
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      wtd_pkg::S_IDLE: in_ready  = !rst;
      wtd_pkg::S_WALK: div_start = walk_done;
      wtd_pkg::S_CALC: ;
      wtd_pkg::S_LOAD: load_out  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- ring write and pointers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wpos] <= sample;
    end
    if (issue_en) begin
      rdata <= ring[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos   <= '0;
      fill   <= '0;
      rptr   <= '0;
      icnt   <= '0;
      rd_vld <= 1'b0;
      rd_tag <= 1'b0;
    end else begin
      rd_vld <= issue_en;
      if (accept) begin
        wpos <= (wpos == AW'(WINDOW - 1)) ? '0 : wpos + 1'b1;
        fill <= fill_next;
        rptr <= wpos;                       // newest slot first
        icnt <= '0;
      end else if (issue_en) begin
        rptr   <= (rptr == '0) ? AW'(WINDOW - 1) : rptr - 1'b1;
        icnt   <= icnt + 1'b1;
        rd_tag <= (icnt < k_cnt);           // newest n/2 are "recent"
      end
    end
  end

  // ---- accumulation over the walk ----
  always_ff @(posedge clk) begin
    if (accept) begin
      total  <= '0;
      recent <= '0;
      prior  <= '0;
    end else if (rd_vld) begin
      total <= total + SW'(rdata);
      if (rd_tag) begin
        recent <= recent + SW'(rdata);
      end else begin
        prior <= prior + SW'(rdata);
      end
    end
  end

  // ---- multiplier schedule: Sr*p, Sp*k, k*p, then compare ----
  always_comb begin
    unique case (mstep)
      wtd_pkg::M_RP: begin
        mul_a = recent;
        mul_b = $signed({1'b0, p_cnt});
      end
      wtd_pkg::M_PK: begin
        mul_a = prior;
        mul_b = $signed({1'b0, k_cnt});
      end
      default: begin
        mul_a = $signed(SW'(k_cnt));
        mul_b = $signed({1'b0, p_cnt});
      end
    endcase
  end

  assign kp_ext = DFW'(mul_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      mstep <= wtd_pkg::M_RP;
    end else if (div_start) begin
      mstep <= wtd_pkg::M_RP;
    end else if (state == wtd_pkg::S_CALC) begin
      unique case (mstep)
        wtd_pkg::M_RP:  mstep <= wtd_pkg::M_PK;
        wtd_pkg::M_PK:  mstep <= wtd_pkg::M_KP;
        wtd_pkg::M_KP:  mstep <= wtd_pkg::M_CMP;
        wtd_pkg::M_CMP: mstep <= wtd_pkg::M_CMP;
        default:        mstep <= wtd_pkg::M_RP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == wtd_pkg::S_CALC) begin
      unique case (mstep)
        wtd_pkg::M_RP: mul_q <= PW'(mul_a) * PW'(mul_b);
        wtd_pkg::M_PK: begin
          prod_rp <= mul_q;
          mul_q   <= PW'(mul_a) * PW'(mul_b);
        end
        wtd_pkg::M_KP: begin
          diff2 <= (DFW'(prod_rp) - DFW'(mul_q)) <<< 1;
          mul_q <= PW'(mul_a) * PW'(mul_b);
        end
        wtd_pkg::M_CMP: begin
          // exact threshold: 2*(Sr*p - Sp*k) against +-k*p
          if (fill < CW'(2)) begin
            trend_r <= wtd_pkg::TREND_FLAT;
          end else if (diff2 > kp_ext) begin
            trend_r <= wtd_pkg::TREND_UP;
          end else if (diff2 < -kp_ext) begin
            trend_r <= wtd_pkg::TREND_DOWN;
          end else begin
            trend_r <= wtd_pkg::TREND_FLAT;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- mean: |total| * 256 / n, sign restored afterwards ----
  assign total_neg = total[SW-1];
  assign tot_mag   = total_neg ? SW'(-total) : SW'(total);
  assign dividend  = {tot_mag, {wtd_pkg::FRAC_BITS{1'b0}}};
  assign avg_full  = total_neg ? (~quotient + 1'b1) : quotient;

  wtd_div #(
    .NW   (DW),
    .DWID (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (fill),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average_q8   <= $signed(avg_full[wtd_pkg::AVG_W-1:0]);
      trend        <= trend_r;
      samples_held <= wtd_pkg::HELD_W'(fill);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW))
    else $error("fill count beyond window");

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == wtd_pkg::S_WALK) && (icnt == '0))
    else $error("accepted transaction did not start a walk");

  a_div_in_calc: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == wtd_pkg::S_CALC))
    else $error("divider running outside calc phase");

  a_load_done: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!div_busy && mstep == wtd_pkg::M_CMP))
    else $error("result loaded before arithmetic finished");

  a_rptr_range: assert property (@(posedge clk) disable iff (rst)
    issue_en |-> (rptr <= AW'(WINDOW - 1)))
    else $error("ring read beyond window");
`endif

endmodule

[sv/wtd_div.sv]
module wtd_div #(
  parameter int NW   = 30,
  parameter int DWID = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   dividend,
  input  logic [DWID-1:0] divisor,
  output logic            busy,
  output logic [NW-1:0]   quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   quo;
  logic [DWID-1:0] rem;
  logic [DWID-1:0] dsr;
  logic [DWID:0]   shifted;
  logic [DWID:0]   trial;

  // restoring step: one quotient bit per cycle, MSB first
  assign shifted = {rem, quo[NW-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(NW);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[DWID]) begin
        rem <= trial[DWID-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DWID-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule
